FILE: hw/rtl/bounded_sequence_list_macros.svh
// ----------------------------------------------------------------------------
// bounded_sequence_list_macros.svh
// Assertion macros shared by the checker of the list block.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_SEQUENCE_LIST_MACROS_SVH
`define BOUNDED_SEQUENCE_LIST_MACROS_SVH

// Concurrent check on the rising clock, off while reset is asserted
`define BSL_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Check that only applies while a result item is presented
`define BSL_ASSERT_VALID(label, clk, rst_n, vld, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) \
		(vld) |-> (prop)) else $error(msg);

`endif

FILE: hw/rtl/bsl_pkg.sv
// ----------------------------------------------------------------------------
// bsl_pkg
// Types, constants and operation codes of the bounded sequence list.
// ----------------------------------------------------------------------------
package bsl_pkg;

	localparam int DEPTH   = 16;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int VAL_W   = 32;
	localparam int POS_W   = 8;
	localparam int OP_W    = 3;
	localparam int CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
	localparam int IN_W    = VAL_W + POS_W;
	localparam int IN_TW   = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W   = CNT_W + 1 + 1 + VAL_W + 1;
	localparam int OUT_TW  = ((OUT_W + 7) / 8) * 8;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_INSERT     = 3'd4,
		OP_READ       = 3'd5
	} op_t;

	// Command broadcast to every cell of the chain
	typedef struct packed {
		logic             ins_en;
		logic [IDX_W-1:0] ins_idx;
		logic             pop_en;
		logic             rd_en;
		logic [IDX_W-1:0] rd_idx;
	} cell_cmd_t;

endpackage

FILE: hw/rtl/bsl_cell.sv
// ----------------------------------------------------------------------------
// bsl_cell
// One list slot: holds a value, takes a neighbor's value on a shift, loads
// the new value on an insert at its own place, and offers its value on a read.
// ----------------------------------------------------------------------------
module bsl_cell (
	input  logic                                    clk,
	input  bsl_pkg::cell_cmd_t                      cmd,
	input  logic [bsl_pkg::IDX_W-1:0]               my_idx,
	input  logic signed [bsl_pkg::VAL_W-1:0]        new_value,
	input  logic signed [bsl_pkg::VAL_W-1:0]        left_data,
	input  logic signed [bsl_pkg::VAL_W-1:0]        right_data,
	output logic signed [bsl_pkg::VAL_W-1:0]        data,
	output logic signed [bsl_pkg::VAL_W-1:0]        rd_data
);
	import bsl_pkg::*;

	logic signed [VAL_W-1:0] data_q;
	logic signed [VAL_W-1:0] data_d;

	// Pick the next slot value from the broadcast command
	always_comb begin
		data_d = data_q;
		if (cmd.ins_en) begin
			if (my_idx > cmd.ins_idx) begin
				data_d = left_data;
			end else if (my_idx == cmd.ins_idx) begin
				data_d = new_value;
			end
		end else if (cmd.pop_en) begin
			data_d = right_data;
		end
	end

	// Hold the slot value
	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data    = data_q;
	assign rd_data = (cmd.rd_en && (my_idx == cmd.rd_idx)) ? data_q : '0;

endmodule

FILE: hw/rtl/bsl_chain.sv
// ----------------------------------------------------------------------------
// bsl_chain
// Row of list cells, each linked to its neighbors, with the read taps merged.
// ----------------------------------------------------------------------------
module bsl_chain (
	input  logic                                clk,
	input  bsl_pkg::cell_cmd_t                  cmd,
	input  logic signed [bsl_pkg::VAL_W-1:0]    new_value,
	output logic signed [bsl_pkg::VAL_W-1:0]    rd_data
);
	import bsl_pkg::*;

	logic signed [VAL_W-1:0] cell_data [DEPTH];
	logic signed [VAL_W-1:0] cell_rd   [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [VAL_W-1:0] left_d;
		logic signed [VAL_W-1:0] right_d;

		// Wire the neighbors; ends fall back to the new value or own data
		if (i == 0) begin : g_first
			assign left_d = new_value;
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_d = cell_data[i];
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
		end

		bsl_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.my_idx     (IDX_W'(i)),
			.new_value  (new_value),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[i]),
			.rd_data    (cell_rd[i])
		);
	end

	// Merge the read taps; at most one cell is selected
	always_comb begin
		rd_data = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_data = rd_data | cell_rd[i];
		end
	end

endmodule

FILE: hw/rtl/bounded_sequence_list.sv
// A result item appears in the cycle after its input item is accepted.
// Throughput: one item per cycle while the receiver takes results; every cell shifts or holds in the same cycle.
// The output register frees the input side whenever the result is taken.
// Reset (arst_n low) clears the count and the output valid at once; the
// slots are not cleared and are only read below the count.
// ----------------------------------------------------------------------------
// bounded_sequence_list
// Double-ended list with positional insert and read, built as a cell chain.
// ----------------------------------------------------------------------------
module bounded_sequence_list (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// tdata: item_value[31:0], position[39:32]
	input  logic [bsl_pkg::IN_TW-1:0]       s_tdata,
	// tuser: operation[2:0]
	input  logic [bsl_pkg::OP_W-1:0]        s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// tdata: entry_count[4:0], is_empty[5], dropped_full[6],
	//        read_value[38:7], read_valid[39]
	output logic [bsl_pkg::OUT_TW-1:0]      m_tdata
);
	import bsl_pkg::*;

	logic                    accept;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        count_d;
	logic signed [VAL_W-1:0] item_value;
	logic signed [POS_W-1:0] position;
	logic signed [CMP_W-1:0] pos_ext;
	logic signed [CMP_W-1:0] cnt_ext;
	logic                    full;
	logic                    empty;
	logic                    dropped;
	logic                    rd_ok;
	cell_cmd_t               cmd;
	logic signed [VAL_W-1:0] rd_data;

	logic                    m_tvalid_q;
	logic [CNT_W-1:0]        cnt_out_q;
	logic                    empty_out_q;
	logic                    drop_out_q;
	logic signed [VAL_W-1:0] rval_out_q;
	logic                    rvalid_out_q;

	assign item_value = s_tdata[VAL_W-1:0];
	assign position   = s_tdata[VAL_W+POS_W-1:VAL_W];
	assign s_tready   = !m_tvalid_q || m_tready;
	assign accept     = s_tvalid && s_tready;

	assign pos_ext = CMP_W'(position);
	assign cnt_ext = $signed(CMP_W'(count_q));
	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);

	// Decode the operation into a cell command and the next count
	always_comb begin
		cmd         = '0;
		cmd.rd_idx  = IDX_W'($unsigned(position));
		count_d     = count_q;
		dropped     = 1'b0;
		rd_ok       = 1'b0;
		unique case (s_tuser)
			OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: begin
				if (full) begin
					dropped = 1'b1;
				end else begin
					cmd.ins_en = accept;
					count_d    = count_q + CNT_W'(1);
					if (s_tuser == OP_PUSH_BACK) begin
						cmd.ins_idx = IDX_W'(count_q);
					end else if (s_tuser == OP_PUSH_FRONT || pos_ext <= 0) begin
						cmd.ins_idx = '0;
					end else if (pos_ext >= cnt_ext) begin
						cmd.ins_idx = IDX_W'(count_q);
					end else begin
						cmd.ins_idx = IDX_W'($unsigned(position));
					end
				end
			end
			OP_POP_FRONT: begin
				if (!empty) begin
					cmd.pop_en = accept;
					count_d    = count_q - CNT_W'(1);
				end
			end
			OP_POP_BACK: begin
				if (!empty) begin
					count_d = count_q - CNT_W'(1);
				end
			end
			OP_READ: begin
				rd_ok     = (pos_ext >= 0) && (pos_ext < cnt_ext);
				cmd.rd_en = rd_ok;
			end
			default: begin
			end
		endcase
	end

	bsl_chain u_chain (
		.clk       (clk),
		.cmd       (cmd),
		.new_value (item_value),
		.rd_data   (rd_data)
	);

	// Load the next count and set the output valid on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q    <= count_d;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Capture the result item
	always_ff @(posedge clk) begin
		if (accept) begin
			cnt_out_q    <= count_d;
			empty_out_q  <= (count_d == '0);
			drop_out_q   <= dropped;
			rval_out_q   <= rd_data;
			rvalid_out_q <= rd_ok;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_TW'({rvalid_out_q, rval_out_q, drop_out_q, empty_out_q, cnt_out_q});

endmodule

FILE: hw/rtl/bsl_checker.sv
// ----------------------------------------------------------------------------
// bsl_checker
// Port-level checks of the list block, bound to the top level.
// ----------------------------------------------------------------------------
`include "bounded_sequence_list_macros.svh"

module bsl_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [bsl_pkg::IN_TW-1:0]       s_tdata,
	input  logic [bsl_pkg::OP_W-1:0]        s_tuser,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [bsl_pkg::OUT_TW-1:0]      m_tdata
);
	import bsl_pkg::*;

	logic [CNT_W-1:0] cnt;
	logic             emp;
	logic             drp;
	logic [VAL_W-1:0] rval;
	logic             rvld;
	logic             unused_in;

	assign cnt  = m_tdata[CNT_W-1:0];
	assign emp  = m_tdata[CNT_W];
	assign drp  = m_tdata[CNT_W+1];
	assign rval = m_tdata[CNT_W+VAL_W+1:CNT_W+2];
	assign rvld = m_tdata[CNT_W+VAL_W+2];
	assign unused_in = s_tvalid ^ s_tready ^ (^s_tdata) ^ (^s_tuser);

	// Empty flag follows the count
	`BSL_ASSERT_VALID(a_empty_flag, clk, arst_n, m_tvalid, emp == (cnt == '0), "empty flag wrong")
	// Count never exceeds the store
	`BSL_ASSERT_VALID(a_count_max, clk, arst_n, m_tvalid, cnt <= CNT_W'(DEPTH), "count overflow")
	// A read result carries no drop, and a miss reads zero
	`BSL_ASSERT_VALID(a_read_drop, clk, arst_n, m_tvalid, !(rvld && drp), "read flagged dropped")
	`BSL_ASSERT_VALID(a_miss_zero, clk, arst_n, m_tvalid, rvld || (rval == '0), "miss not zero")
	// A stalled result holds
	`BSL_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

endmodule

bind bounded_sequence_list bsl_checker u_bsl_checker (.*);

FILE: test/tb_bounded_sequence_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_sequence_list
// Self-checking bench for the double-ended list. A short table walks empty,
// full and out-of-range cases, then random push, pop, insert and read items
// run under several idle and stall mixes. Each result item is checked against
// the expected result of a typed table row, else a mirror kept in the bench.
// ----------------------------------------------------------------------------
module tb_bounded_sequence_list;

	import bsl_pkg::*;

	// Codes outside the operation set; the block must leave the list alone
	localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;
	localparam bit TYPED = 1'b1;
	localparam bit MIRROR = 1'b0;
	localparam int RAND_PER_PHASE = 275;
	localparam int MAX_REPORTS = 40;

	// Result item, read_valid in the top bit down to entry_count at bit 0
	typedef struct packed {
		logic             read_valid;
		logic [VAL_W-1:0] read_value;
		logic             dropped_full;
		logic             is_empty;
		logic [CNT_W-1:0] entry_count;
	} list_result_t;

	typedef struct {
		logic [OP_W-1:0]  op;
		logic [VAL_W-1:0] val;
		logic [POS_W-1:0] pos;
		int               reps;
		bit               typed;
		list_result_t     res;
	} stim_row_t;

	typedef struct {
		bit           typed;
		list_result_t res;
	} typed_slot_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [IN_TW-1:0]     s_tdata = '0;
	logic [OP_W-1:0]      s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OUT_TW-1:0]    m_tdata;

	// Mirror of the list contents and length
	logic [VAL_W-1:0]     list_mirror [DEPTH];
	int                   list_len = 0;

	list_result_t         pending_results_q [$];
	typed_slot_t          typed_rows_q [$];
	stim_row_t            dir_rows [25];
	int                   fail_count = 0;
	int                   idle_pct = 0;
	int                   stall_pct = 0;
	bit                   fill_tide = 1'b1;
	int                   tide_left = 30;

	bounded_sequence_list dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Apply one operation to the mirror and return the result it must give
	function automatic list_result_t list_apply(input logic [OP_W-1:0] op,
			input logic [VAL_W-1:0] val, input logic [POS_W-1:0] pos_raw);
		list_result_t r;
		int p;
		int slot;
		r = '0;
		p = int'($signed(pos_raw));
		case (op)
			OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: begin
				if (list_len >= DEPTH) begin
					r.dropped_full = 1'b1;
				end else begin
					if (op == OP_PUSH_BACK)
						slot = list_len;
					else if (op == OP_PUSH_FRONT || p <= 0)
						slot = 0;
					else if (p >= list_len)
						slot = list_len;
					else
						slot = p;
					for (int i = list_len; i > slot; i--)
						list_mirror[i] = list_mirror[i-1];
					list_mirror[slot] = val;
					list_len++;
				end
			end
			OP_POP_FRONT: begin
				if (list_len > 0) begin
					for (int i = 0; i + 1 < list_len; i++)
						list_mirror[i] = list_mirror[i+1];
					list_len--;
				end
			end
			OP_POP_BACK: begin
				if (list_len > 0)
					list_len--;
			end
			OP_READ: begin
				if (p >= 0 && p < list_len) begin
					r.read_valid = 1'b1;
					r.read_value = list_mirror[p];
				end
			end
			default: ;
		endcase
		r.entry_count = CNT_W'(list_len);
		r.is_empty = (list_len == 0);
		return r;
	endfunction

	function automatic stim_row_t row(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val,
			input logic [POS_W-1:0] pos, input int reps, input bit typed, input int cnt,
			input bit dropped, input bit rvalid, input logic [VAL_W-1:0] rval);
		stim_row_t s;
		s.op = op;
		s.val = val;
		s.pos = pos;
		s.reps = reps;
		s.typed = typed;
		s.res.entry_count = CNT_W'(cnt);
		s.res.is_empty = (cnt == 0);
		s.res.dropped_full = dropped;
		s.res.read_valid = rvalid;
		s.res.read_value = rval;
		return s;
	endfunction

	// Present one item after a random gap and hold it until taken
	task automatic send_item(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val,
			input logic [POS_W-1:0] pos);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {pos, val};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Draw a list operation; the tide swings the list between filling and draining
	task automatic pick_list_op(output logic [OP_W-1:0] op, output logic [VAL_W-1:0] val,
			output logic [POS_W-1:0] pos);
		int roll;
		int push_w;
		int p;
		if (tide_left == 0) begin
			fill_tide = !fill_tide;
			tide_left = $urandom_range(50, 15);
		end
		tide_left--;
		push_w = fill_tide ? 55 : 20;
		roll = $urandom_range(99);
		if (roll < 3)
			op = roll[0] ? OP_RSVD_7 : OP_RSVD_6;
		else if (roll < 25)
			op = OP_READ;
		else if (roll < 25 + push_w) begin
			case ($urandom_range(2))
				0: op = OP_PUSH_BACK;
				1: op = OP_PUSH_FRONT;
				default: op = OP_INSERT;
			endcase
		end else
			op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;

		roll = $urandom_range(99);
		if (roll < 80)
			val = $urandom;
		else if (roll < 90) begin
			case ($urandom_range(3))
				0: val = 32'h7FFF_FFFF;
				1: val = 32'h8000_0000;
				2: val = 32'h0000_0000;
				default: val = 32'hFFFF_FFFF;
			endcase
		end else
			val = $urandom_range(15);

		// Mostly near the live range, sometimes anywhere in the field
		if ($urandom_range(99) < 70) begin
			p = int'($urandom_range(list_len + 1)) - 1;
			pos = p[POS_W-1:0];
		end else
			pos = POS_W'($urandom);
	endtask

	// Receiver stall pattern
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	// Predict on every accepted item, check every taken result item
	always @(posedge clk) begin
		list_result_t predicted;
		list_result_t got;
		list_result_t want;
		typed_slot_t slot;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predicted = list_apply(s_tuser, s_tdata[VAL_W-1:0], s_tdata[IN_W-1:VAL_W]);
				if (typed_rows_q.size() != 0) begin
					slot = typed_rows_q.pop_front();
					if (slot.typed)
						predicted = slot.res;
				end
				pending_results_q.push_back(predicted);
			end
			if (m_tvalid && m_tready) begin
				got = list_result_t'(m_tdata[OUT_W-1:0]);
				if (pending_results_q.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$error("result item with no expectation waiting");
				end else begin
					want = pending_results_q.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS) begin
							if (got.entry_count !== want.entry_count)
								$error("entry_count: expected %0d, got %0d",
									want.entry_count, got.entry_count);
							if (got.is_empty !== want.is_empty)
								$error("is_empty: expected %0b, got %0b",
									want.is_empty, got.is_empty);
							if (got.dropped_full !== want.dropped_full)
								$error("dropped_full: expected %0b, got %0b",
									want.dropped_full, got.dropped_full);
							if (got.read_value !== want.read_value)
								$error("read_value: expected %h, got %h",
									want.read_value, got.read_value);
							if (got.read_valid !== want.read_valid)
								$error("read_valid: expected %0b, got %0b",
									want.read_valid, got.read_valid);
						end
					end
				end
			end
		end
	end

	initial begin
		logic [OP_W-1:0] op;
		logic [VAL_W-1:0] val;
		logic [POS_W-1:0] pos;
		typed_slot_t slot;

		// Walk from empty to full, read past both ends, and pop from each end
		dir_rows = '{
			row(OP_POP_FRONT,  32'h0,         8'h00, 1, TYPED,  0, 0, 0, 32'h0),
			row(OP_POP_BACK,   32'h0,         8'h00, 1, TYPED,  0, 0, 0, 32'h0),
			row(OP_READ,       32'h0,         8'h00, 1, TYPED,  0, 0, 0, 32'h0),
			row(OP_RSVD_6,     32'hFFFF_FFFF, 8'hFF, 1, TYPED,  0, 0, 0, 32'h0),
			row(OP_PUSH_BACK,  32'h7FFF_FFFF, 8'h00, 1, TYPED,  1, 0, 0, 32'h0),
			row(OP_PUSH_FRONT, 32'h8000_0000, 8'h00, 1, TYPED,  2, 0, 0, 32'h0),
			row(OP_READ,       32'h0,         8'h00, 1, TYPED,  2, 0, 1, 32'h8000_0000),
			row(OP_READ,       32'h0,         8'h01, 1, TYPED,  2, 0, 1, 32'h7FFF_FFFF),
			row(OP_READ,       32'h0,         8'hFF, 1, TYPED,  2, 0, 0, 32'h0),
			row(OP_READ,       32'h0,         8'h7F, 1, TYPED,  2, 0, 0, 32'h0),
			row(OP_INSERT,     32'hFFFF_FFFF, 8'h80, 1, MIRROR, 0, 0, 0, 32'h0),
			row(OP_INSERT,     32'h0000_0000, 8'h7F, 1, MIRROR, 0, 0, 0, 32'h0),
			row(OP_INSERT,     32'h5555_5555, 8'h02, 1, MIRROR, 0, 0, 0, 32'h0),
			row(OP_INSERT,     32'hAAAA_AAAA, 8'h00, 1, MIRROR, 0, 0, 0, 32'h0),
			row(OP_INSERT,     32'h1234_5678, 8'h01, 1, MIRROR, 0, 0, 0, 32'h0),
			row(OP_READ,       32'h0,         8'h02, 1, MIRROR, 0, 0, 0, 32'h0),
			row(OP_RSVD_7,     32'h0,         8'h00, 1, MIRROR, 0, 0, 0, 32'h0),
			row(OP_PUSH_BACK,  32'h0000_0100, 8'h00, 9, MIRROR, 0, 0, 0, 32'h0),
			row(OP_PUSH_BACK,  32'h0BAD_0001, 8'h00, 1, TYPED, 16, 1, 0, 32'h0),
			row(OP_PUSH_FRONT, 32'h0BAD_0002, 8'h00, 1, TYPED, 16, 1, 0, 32'h0),
			row(OP_INSERT,     32'h0BAD_0003, 8'h03, 1, TYPED, 16, 1, 0, 32'h0),
			row(OP_READ,       32'h0,         8'h0F, 1, MIRROR, 0, 0, 0, 32'h0),
			row(OP_READ,       32'h0,         8'h10, 1, TYPED, 16, 0, 0, 32'h0),
			row(OP_POP_FRONT,  32'h0,         8'h00, 1, MIRROR, 0, 0, 0, 32'h0),
			row(OP_POP_BACK,   32'h0,         8'h00, 3, MIRROR, 0, 0, 0, 32'h0)
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, no idling on either side
		foreach (dir_rows[i]) begin
			for (int k = 0; k < dir_rows[i].reps; k++) begin
				slot.typed = dir_rows[i].typed;
				slot.res = dir_rows[i].res;
				typed_rows_q.push_back(slot);
				send_item(dir_rows[i].op, dir_rows[i].val + VAL_W'(k), dir_rows[i].pos);
			end
		end

		// Random items under each idle and stall mix
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 61; stall_pct = 0;  end
				1: begin idle_pct = 0;  stall_pct = 61; end
				2: begin idle_pct = 28; stall_pct = 28; end
				default: begin idle_pct = 0; stall_pct = 0; end
			endcase
			repeat (RAND_PER_PHASE) begin
				pick_list_op(op, val, pos);
				send_item(op, val, pos);
			end
		end
		s_tvalid <= 1'b0;

		// Drain, then give the output register time for any stray item
		while (pending_results_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/bsl_pkg.sv
hw/rtl/bsl_cell.sv
hw/rtl/bsl_chain.sv
hw/rtl/bounded_sequence_list.sv
hw/rtl/bsl_checker.sv
test/tb_bounded_sequence_list.sv
